FILE: rtl/lhe_pkg.sv
`timescale 1ns / 1ps
// Package of the link hop emulator: verdict codes, configuration register
// indexes and fixed constants. No dependencies.
package lhe_pkg;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_KBYTES    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_TICK = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_SLOTS    = 8'd3;

  localparam logic [1:0] VERDICT_QUEUED   = 2'd0;
  localparam logic [1:0] VERDICT_LOST     = 2'd1;
  localparam logic [1:0] VERDICT_OVERFLOW = 2'd2;

  localparam logic [15:0] FAST_LINK_BYTES = 16'd50;
  localparam logic [31:0] BYTES_PER_KBYTE = 32'd1000;
  localparam logic [21:0] QUEUE_BYTES_MAX = 22'h3fffff;
  localparam logic [6:0]  QUEUE_SLOTS_RESET = 7'd64;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 56;

endpackage

FILE: rtl/link_hop_emulator.sv
`timescale 1ns / 1ps
// Top level of the link hop emulator: sequencer, shared iterative divider
// and the two slot memories. Depends on lhe_pkg.
//
// One packet is handled at a time. A packet enters on the slave stream, the
// block drains expired queue slots when a rate is set (one memory read each),
// decides loss and overflow, reads the tail slot, computes the transmit delay
// with a 32-step restoring divider (one division on slow links, two on links
// above fifty bytes per tick with a nonzero length) and writes the new slot
// back. Lost, overflowing and unlimited-rate packets skip the delay division.
// A shrunken slot count that leaves the head index out of range first has the
// head index reduced with the divider. The result waits in an output register
// while the next packet is already accepted; a packet that finishes while that
// register is still held waits for its transfer. After reset the block clears
// both slot memories, one slot per cycle, and accepts no packet until every
// slot is cleared. A drained slot is written back as zero.
module link_hop_emulator #(
  parameter int unsigned MAX_SLOTS        = 64,
  parameter int unsigned TICKS_PER_SECOND = 1000
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lhe_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [lhe_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // packet_length[15:0], current_tick[47:16], random_word[79:48]
  input  logic [lhe_pkg::IN_DATA_W-1:0]        s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // exit_tick[31:0], forward_now[32], zero_delay[33], queue_bytes[55:34]
  output logic [lhe_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o,
  // verdict[1:0]
  output logic [1:0]                           m_axis_tuser_o
);
  import lhe_pkg::*;

  localparam int unsigned SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned QW = $clog2(MAX_SLOTS + 1);
  // The byte count can drift above the sum of queued lengths after the slot
  // count shrinks, so it is kept at full word width.
  localparam int unsigned HW = 32;

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_HMOD, ST_HDIV, ST_DRD, ST_DCHK, ST_DECIDE,
    ST_TCHK, ST_DIVA, ST_DIVB, ST_COMMIT, ST_OUT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [30:0] thr_q;
  logic [21:0] rate_q;
  logic [15:0] bpt_q;
  logic [6:0]  slots_q;

  // Queue state.
  logic [SW-1:0] head_q;
  logic [QW-1:0] occ_q;
  logic [HW-1:0] held_q;
  logic [SW-1:0] init_q;

  // Packet registers.
  logic [15:0] len_q;
  logic [31:0] now_q;
  logic [31:0] rnd_q;
  logic [31:0] tail_q;
  logic [31:0] delay_q;
  logic [31:0] quot1_q;
  logic [31:0] rem1_q;
  logic        fast_q;
  logic [1:0]  res_verdict_q;
  logic [31:0] res_exit_q;
  logic        res_fwd_q;
  logic        res_zd_q;

  // Divider.
  logic [31:0] div_n_q;
  logic [31:0] div_r_q;
  logic [31:0] div_d_q;
  logic [4:0]  div_cnt_q;
  logic [32:0] div_rsh;
  logic [33:0] div_diff;
  logic        div_ge;
  logic [31:0] div_r_next;
  logic [31:0] div_n_next;
  logic        div_last;

  // Output register.
  logic                  m_valid_q;
  logic [1:0]            out_verdict_q;
  logic [31:0]           out_exit_q;
  logic                  out_fwd_q;
  logic                  out_zd_q;
  logic [21:0]           out_qb_q;

  // Memories.
  logic [31:0] exit_mem [MAX_SLOTS];
  logic [15:0] len_mem  [MAX_SLOTS];
  logic [31:0] rd_exit_q;
  logic [15:0] rd_len_q;
  logic [SW-1:0] rd_addr;
  logic          mem_we;
  logic [SW-1:0] wr_addr;
  logic [31:0]   wr_exit;
  logic [15:0]   wr_len;
  logic [31:0]   exit_next;

  logic [31:0]   slots32;
  logic [QW-1:0] q_eff;
  logic [QW:0]   tail_sum, tail_wrap, ns_sum, ns_wrap, head_inc;
  logic [SW-1:0] tail_idx, ns_idx;
  logic          lost, full;

  always_comb begin
    slots32 = 32'(slots_q);
    if (slots32 == 32'd0) begin
      q_eff = QW'(1);
    end else if (slots32 > 32'(MAX_SLOTS)) begin
      q_eff = QW'(MAX_SLOTS);
    end else begin
      q_eff = QW'(slots32);
    end
  end

  // Both sums stay below twice the slot count when the queue is not full.
  always_comb begin
    tail_sum  = (QW+1)'(head_q) + (QW+1)'(occ_q) - (QW+1)'(1);
    tail_wrap = (tail_sum >= (QW+1)'(q_eff)) ? tail_sum - (QW+1)'(q_eff) : tail_sum;
    tail_idx  = SW'(tail_wrap);
    ns_sum    = (QW+1)'(head_q) + (QW+1)'(occ_q);
    ns_wrap   = (ns_sum >= (QW+1)'(q_eff)) ? ns_sum - (QW+1)'(q_eff) : ns_sum;
    ns_idx    = SW'(ns_wrap);
    head_inc  = (QW+1)'(head_q) + (QW+1)'(1);
  end

  assign lost = (thr_q != 31'd0) && (rnd_q[30:0] < thr_q);
  assign full = (rate_q != 22'd0) && (occ_q >= q_eff);

  always_comb begin
    div_rsh    = {div_r_q, div_n_q[31]};
    div_diff   = {1'b0, div_rsh} - {2'b00, div_d_q};
    div_ge     = !div_diff[33];
    div_r_next = div_ge ? div_diff[31:0] : div_rsh[31:0];
    div_n_next = {div_n_q[30:0], div_ge};
    div_last   = (div_cnt_q == 5'd31);
  end

  assign rd_addr   = (state_q == ST_DECIDE) ? tail_idx : head_q;
  assign exit_next = tail_q + delay_q;

  // Write port: clearing after reset, zeroing a drained slot, or the new slot.
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = ns_idx;
    wr_exit = exit_next;
    wr_len  = len_q;
    case (state_q)
      ST_INIT: begin
        mem_we  = 1'b1;
        wr_addr = init_q;
        wr_exit = '0;
        wr_len  = '0;
      end
      ST_DCHK: begin
        mem_we  = (rd_exit_q < now_q);
        wr_addr = head_q;
        wr_exit = '0;
        wr_len  = '0;
      end
      ST_COMMIT: begin
        mem_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Every read whose data is used comes after the write to the same slot,
  // so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      exit_mem[wr_addr] <= wr_exit;
      len_mem[wr_addr]  <= wr_len;
    end
    rd_exit_q <= exit_mem[rd_addr];
    rd_len_q  <= len_mem[rd_addr];
  end

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {out_qb_q, out_zd_q, out_fwd_q, out_exit_q};
  assign m_axis_tuser_o  = out_verdict_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      thr_q     <= '0;
      rate_q    <= '0;
      bpt_q     <= '0;
      slots_q   <= QUEUE_SLOTS_RESET;
      head_q    <= '0;
      occ_q     <= '0;
      held_q    <= '0;
      init_q    <= '0;
      m_valid_q <= 1'b0;
      div_cnt_q <= '0;
      fast_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_LOSS_THRESHOLD: thr_q   <= cfg_data_i[30:0];
          CFG_RATE_KBYTES:    rate_q  <= cfg_data_i[21:0];
          CFG_BYTES_PER_TICK: bpt_q   <= cfg_data_i[15:0];
          CFG_QUEUE_SLOTS:    slots_q <= cfg_data_i[6:0];
          default: ;
        endcase
      end

      // The output step reloads the register itself when it moves on.
      if (m_valid_q && m_axis_tready_i && (state_q != ST_OUT)) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_INIT: begin
          init_q <= init_q + SW'(1);
          if (init_q == SW'(MAX_SLOTS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            len_q   <= s_axis_tdata_i[15:0];
            now_q   <= s_axis_tdata_i[47:16];
            rnd_q   <= s_axis_tdata_i[79:48];
            state_q <= ST_HMOD;
          end
        end
        ST_HMOD: begin
          if (QW'(head_q) >= q_eff) begin
            div_n_q   <= 32'(head_q);
            div_d_q   <= 32'(q_eff);
            div_r_q   <= '0;
            div_cnt_q <= '0;
            state_q   <= ST_HDIV;
          end else begin
            state_q <= (rate_q != 22'd0) ? ST_DRD : ST_DECIDE;
          end
        end
        ST_HDIV: begin
          div_n_q   <= div_n_next;
          div_r_q   <= div_r_next;
          div_cnt_q <= div_cnt_q + 5'd1;
          if (div_last) begin
            head_q  <= SW'(div_r_next);
            state_q <= (rate_q != 22'd0) ? ST_DRD : ST_DECIDE;
          end
        end
        ST_DRD: begin
          state_q <= (occ_q != '0) ? ST_DCHK : ST_DECIDE;
        end
        ST_DCHK: begin
          if (rd_exit_q < now_q) begin
            occ_q   <= occ_q - QW'(1);
            held_q  <= (held_q >= HW'(rd_len_q)) ? held_q - HW'(rd_len_q) : '0;
            head_q  <= (head_inc >= (QW+1)'(q_eff)) ? '0 : SW'(head_inc);
            state_q <= ST_DRD;
          end else begin
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          res_zd_q <= 1'b0;
          if (lost) begin
            res_verdict_q <= VERDICT_LOST;
            res_exit_q    <= '0;
            res_fwd_q     <= 1'b0;
            state_q       <= ST_OUT;
          end else if (full) begin
            res_verdict_q <= VERDICT_OVERFLOW;
            res_exit_q    <= '0;
            res_fwd_q     <= 1'b0;
            state_q       <= ST_OUT;
          end else if (rate_q == 22'd0) begin
            res_verdict_q <= VERDICT_QUEUED;
            res_exit_q    <= now_q;
            res_fwd_q     <= 1'b1;
            state_q       <= ST_OUT;
          end else begin
            res_verdict_q <= VERDICT_QUEUED;
            res_exit_q    <= '0;
            res_fwd_q     <= 1'b0;
            state_q       <= ST_TCHK;
          end
        end
        ST_TCHK: begin
          tail_q    <= (occ_q != '0) ? rd_exit_q : now_q;
          div_r_q   <= '0;
          div_cnt_q <= '0;
          if ((len_q != 16'd0) && (bpt_q > FAST_LINK_BYTES)) begin
            fast_q  <= 1'b1;
            div_n_q <= 32'(len_q);
            div_d_q <= 32'(bpt_q);
          end else begin
            fast_q  <= 1'b0;
            div_n_q <= 32'(len_q) * 32'(TICKS_PER_SECOND);
            div_d_q <= 32'(rate_q) * BYTES_PER_KBYTE;
          end
          state_q <= ST_DIVA;
        end
        ST_DIVA: begin
          div_cnt_q <= div_cnt_q + 5'd1;
          if (div_last && fast_q) begin
            quot1_q <= div_n_next;
            rem1_q  <= div_r_next;
            div_n_q <= rnd_q;
            div_r_q <= '0;
            state_q <= ST_DIVB;
          end else begin
            div_n_q <= div_n_next;
            div_r_q <= div_r_next;
            if (div_last) begin
              delay_q <= div_n_next;
              state_q <= ST_COMMIT;
            end
          end
        end
        ST_DIVB: begin
          div_n_q   <= div_n_next;
          div_r_q   <= div_r_next;
          div_cnt_q <= div_cnt_q + 5'd1;
          if (div_last) begin
            delay_q <= quot1_q + 32'(div_r_next < rem1_q);
            state_q <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          occ_q      <= occ_q + QW'(1);
          held_q     <= held_q + HW'(len_q);
          res_exit_q <= exit_next;
          res_fwd_q  <= (exit_next == now_q);
          res_zd_q   <= (delay_q == 32'd0);
          state_q    <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q     <= 1'b1;
            out_verdict_q <= res_verdict_q;
            out_exit_q    <= res_exit_q;
            out_fwd_q     <= res_fwd_q;
            out_zd_q      <= res_zd_q;
            out_qb_q      <= (32'(held_q) > 32'(QUEUE_BYTES_MAX)) ? QUEUE_BYTES_MAX
                                                                  : 22'(held_q);
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // A slot is only written into a queue that has room.
  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT) |-> (occ_q < q_eff))
    else $error("slot written into a full queue");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= QW'(MAX_SLOTS))
    else $error("occupancy above slot capacity");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result raised outside the output step");

  a_drain_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DCHK) |-> (occ_q != '0))
    else $error("drain check with an empty queue");

endmodule

FILE: tb/lhe_checker.sv
`timescale 1ns / 1ps
// Checker of the link hop emulator: watches the packet and result streams and
// the register port, predicts each result and compares it. Depends on lhe_pkg.
module lhe_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [lhe_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lhe_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            pkt_valid_i,
  input  logic                            pkt_ready_i,
  input  logic [lhe_pkg::IN_DATA_W-1:0]   pkt_data_i,
  input  logic                            res_valid_i,
  input  logic                            res_ready_i,
  input  logic [lhe_pkg::OUT_DATA_W-1:0]  res_data_i,
  input  logic [1:0]                      res_user_i,
  output int unsigned                     pending_o,
  output int unsigned                     errors_o
);
  import lhe_pkg::*;

  localparam int unsigned SLOTS = 64;
  localparam int unsigned TPS   = 1000;

  typedef struct packed {
    logic [21:0] queue_bytes;
    logic        zero_delay;
    logic        forward_now;
    logic [31:0] exit_tick;
    logic [1:0]  verdict;
  } hop_result_t;

  logic [30:0] loss_thr;
  logic [21:0] rate_kb;
  logic [15:0] bpt;
  logic [6:0]  slots_cfg;
  logic [31:0] exit_ring [SLOTS];
  logic [15:0] len_ring [SLOTS];
  int unsigned head, occ;
  logic [31:0] held;
  hop_result_t expected_results [$];

  assign pending_o = expected_results.size();

  function automatic hop_result_t hop_predict(logic [15:0] len, logic [31:0] now,
                                              logic [31:0] rnd);
    hop_result_t r;
    int unsigned q;
    bit lost, full;
    logic [31:0] tail, delay;
    longint unsigned num, den;
    int unsigned ns;
    r = '0;
    q = (slots_cfg == 0) ? 1 : ((slots_cfg > SLOTS) ? SLOTS : slots_cfg);
    lost = 0;
    full = 0;
    if (head >= q) head = head % q;
    if (loss_thr != 0 && rnd[30:0] < loss_thr) lost = 1;
    if (rate_kb != 0) begin
      // Retire slots whose exit tick has already passed; a retired slot reads
      // as zero afterwards.
      while (occ != 0 && exit_ring[head] < now) begin
        occ--;
        held = (held >= len_ring[head]) ? held - len_ring[head] : '0;
        exit_ring[head] = '0;
        len_ring[head] = '0;
        head = (head + 1 >= q) ? 0 : head + 1;
      end
      if (occ >= q) full = 1;
    end
    if (lost) begin
      r.verdict = VERDICT_LOST;
    end else if (full) begin
      r.verdict = VERDICT_OVERFLOW;
    end else begin
      r.verdict = VERDICT_QUEUED;
      if (rate_kb == 0) begin
        r.exit_tick = now;
      end else begin
        tail = (occ != 0) ? exit_ring[(head + occ - 1) % q] : now;
        if (len != 0 && bpt > FAST_LINK_BYTES) begin
          delay = len / bpt;
          if ((rnd % bpt) < (len % bpt)) delay++;
        end else begin
          num = longint'(len) * TPS;
          den = longint'(BYTES_PER_KBYTE) * rate_kb;
          delay = 32'(num / den);
        end
        r.zero_delay = (delay == 0);
        r.exit_tick = tail + delay;
        ns = (head + occ) % q;
        occ++;
        len_ring[ns] = len;
        exit_ring[ns] = r.exit_tick;
        held = held + len;
      end
      r.forward_now = (r.exit_tick == now);
    end
    r.queue_bytes = (held > QUEUE_BYTES_MAX) ? QUEUE_BYTES_MAX : held[21:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hop_result_t got, exp_r;
    if (!rst_ni) begin
      loss_thr = '0; rate_kb = '0; bpt = '0; slots_cfg = QUEUE_SLOTS_RESET;
      head = 0; occ = 0; held = '0; errors_o = 0;
      for (int i = 0; i < SLOTS; i++) begin
        exit_ring[i] = '0;
        len_ring[i] = '0;
      end
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_LOSS_THRESHOLD: loss_thr = cfg_data_i[30:0];
          CFG_RATE_KBYTES:    rate_kb = cfg_data_i[21:0];
          CFG_BYTES_PER_TICK: bpt = cfg_data_i[15:0];
          CFG_QUEUE_SLOTS:    slots_cfg = cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (res_valid_i && res_ready_i) begin
        got = {res_data_i, res_user_i};
        if (expected_results.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected result transfer %h", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            errors_o++;
            if (errors_o <= 10)
              $display("mismatch: verdict %0d/%0d exit %h/%h fwd %b/%b zd %b/%b qb %0d/%0d",
                       exp_r.verdict, got.verdict, exp_r.exit_tick, got.exit_tick,
                       exp_r.forward_now, got.forward_now, exp_r.zero_delay,
                       got.zero_delay, exp_r.queue_bytes, got.queue_bytes);
          end
        end
      end
      if (pkt_valid_i && pkt_ready_i)
        expected_results.push_back(hop_predict(pkt_data_i[15:0], pkt_data_i[47:16],
                                               pkt_data_i[79:48]));
    end
  end
endmodule

FILE: tb/tb_link_hop_emulator.sv
`timescale 1ns / 1ps
// Testbench top of the link hop emulator: clock, reset, packet stimulus in
// phases of register settings, and the verdict. Depends on lhe_pkg and lhe_checker.
module tb_link_hop_emulator;
  import lhe_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid_i = 0;
  logic s_axis_tready_o;
  // packet_length, current_tick, random_word from the lowest bit up.
  logic [IN_DATA_W-1:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 0;
  // exit_tick, forward_now, zero_delay, queue_bytes from the lowest bit up.
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  // verdict.
  logic [1:0] m_axis_tuser_o;
  int unsigned pending, errors;
  // A long stall of the result side is requested by the stimulus process.
  bit hold_results = 0;
  // The running tick; packets mostly move it forward by small steps.
  logic [31:0] tick_now = '0;

  link_hop_emulator DUT (.*);

  lhe_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .pkt_valid_i(s_axis_tvalid_i), .pkt_ready_i(s_axis_tready_o), .pkt_data_i(s_axis_tdata_i),
    .res_valid_i(m_axis_tvalid_o), .res_ready_i(m_axis_tready_i), .res_data_i(m_axis_tdata_o),
    .res_user_i(m_axis_tuser_o), .pending_o(pending), .errors_o(errors));

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // Result side: random stalls, plus the long hold-off when asked for.
  initial begin
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (hold_results) begin
        m_axis_tready_i <= 0;
        for (n = 0; n < 3000; n++) @(posedge clk_i);
        hold_results = 0;
      end
      n = gap_len();
      if (n == 0) begin
        m_axis_tready_i <= 1;
        @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 0;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
  endtask

  // Waits for every expected result, then idles with no packet in flight.
  task automatic wait_idle();
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic send_packet(logic [15:0] len, logic [31:0] now, logic [31:0] rnd,
                             bit no_gap);
    int unsigned g;
    g = no_gap ? 0 : gap_len();
    if (g != 0) begin
      s_axis_tvalid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tdata_i <= {rnd, now, len};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic end_burst();
    s_axis_tvalid_i <= 0;
  endtask

  // Random packet; lengths lean small so queues both build and drain.
  task automatic random_packet(bit no_gap);
    logic [15:0] len;
    int unsigned roll;
    roll = $urandom_range(9);
    len = (roll < 6) ? 16'($urandom_range(1500))
                     : ((roll < 9) ? 16'($urandom()) : 16'hffff);
    if (roll == 0) len = 0;
    roll = $urandom_range(19);
    if (roll == 0) tick_now = $urandom();
    else if (roll < 3) tick_now = tick_now - $urandom_range(5);
    else tick_now = tick_now + $urandom_range(roll < 12 ? 2 : 40);
    send_packet(len, tick_now, $urandom(), no_gap);
  endtask

  task automatic configure(logic [30:0] thr, logic [21:0] rate, logic [15:0] bpt,
                           logic [6:0] slots);
    write_reg(CFG_LOSS_THRESHOLD, {1'b0, thr});
    write_reg(CFG_RATE_KBYTES, {10'd0, rate});
    write_reg(CFG_BYTES_PER_TICK, {16'd0, bpt});
    write_reg(CFG_QUEUE_SLOTS, {25'd0, slots});
  endtask

  initial begin
    int unsigned phase, k;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: unlimited rate with field extremes.
    send_packet(16'h0000, 32'h0, 32'h0, 0);
    send_packet(16'hffff, 32'hffffffff, 32'hffffffff, 0);
    send_packet(16'd100, 32'd5, 32'h80000000, 0);
    end_burst();
    wait_idle();
    // Slow link, narrow queue: overflow, zero delay, zero length and wrap.
    configure(31'd0, 22'd1, 16'd0, 7'd2);
    send_packet(16'd0, 32'd10, 32'h1, 0);
    send_packet(16'd1500, 32'd10, 32'h2, 0);
    send_packet(16'd1500, 32'd10, 32'h3, 0);
    send_packet(16'd1500, 32'd10, 32'h4, 0);
    send_packet(16'hffff, 32'hffffffe0, 32'h5, 0);
    send_packet(16'd10, 32'd0, 32'h6, 0);
    end_burst();
    wait_idle();
    // Fast link: remainder rounding, bytes_per_tick at the border, near-total loss.
    configure(31'h7fffffff, 22'h3fffff, 16'd51, 7'd0);
    send_packet(16'd100, 32'd1000, 32'h7fffffff, 0);
    send_packet(16'd100, 32'd1000, 32'hfffffffe, 0);
    send_packet(16'd100, 32'd1000, 32'h0, 0);
    end_burst();
    wait_idle();
    configure(31'd0, 22'd7, 16'd50, 7'd127);
    send_packet(16'd50, 32'd2000, 32'h0, 0);
    send_packet(16'd51, 32'd2000, 32'd50, 0);
    end_burst();
    wait_idle();
    configure(31'd0, 22'd7, 16'hffff, 7'd64);
    send_packet(16'hffff, 32'd3000, 32'hfffe, 0);
    send_packet(16'hfffe, 32'd3000, 32'hffff, 0);
    // Shrink the queue below its occupancy: overflows until it drains.
    end_burst();
    wait_idle();
    configure(31'd0, 22'd7, 16'hffff, 7'd1);
    send_packet(16'd1, 32'd3000, 32'h1, 0);
    send_packet(16'd1, 32'd4000, 32'h1, 0);
    end_burst();
    wait_idle();

    for (phase = 0; phase < 10; phase++) begin
      case (phase % 5)
        0: configure(31'd0, 22'($urandom_range(2000, 1)), 16'($urandom_range(200, 51)),
                     7'($urandom_range(64, 1)));
        1: configure(31'($urandom_range(31'h20000000)), 22'($urandom_range(50, 1)), 16'd0,
                     7'($urandom_range(8, 1)));
        2: configure(31'd0, 22'd0, 16'($urandom()), 7'($urandom_range(127)));
        3: configure(31'($urandom_range(31'h7fffffff)), 22'($urandom()), 16'($urandom()),
                     7'($urandom()));
        default: configure(31'd0, 22'h3fffff, 16'($urandom_range(4000, 51)), 7'd64);
      endcase
      if (phase == 4) hold_results = 1;
      for (k = 0; k < 110; k++) random_packet(phase == 4);
      // The sender stops here until every result is back.
      end_burst();
      wait_idle();
    end

    if (errors == 0) begin
      $display("tb_link_hop_emulator: done, clean");
    end else begin
      $display("tb_link_hop_emulator: done, errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_link_hop_emulator: done, errors");
    $finish;
  end
endmodule

FILE: link_hop_emulator.f
rtl/lhe_pkg.sv
rtl/link_hop_emulator.sv
tb/lhe_checker.sv
tb/tb_link_hop_emulator.sv
